// File: rtl/hevcf_pkg.sv
// Shared types, constants and helper functions of the HEVC NAL to FLV video tag framer.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package hevcf_pkg;

	typedef enum logic {
		CMD_BEGIN = 1'b0,
		CMD_BYTE  = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_CLOSE = 1'b1
	} kind_t;

	// NAL unit types that keep the next NAL in the same message.
	localparam logic [5:0] NAL_VPS        = 6'd32;
	localparam logic [5:0] NAL_SPS        = 6'd33;
	localparam logic [5:0] NAL_PPS        = 6'd34;
	localparam logic [5:0] NAL_SEI_PREFIX = 6'd39;
	localparam logic [5:0] NAL_SEI_SUFFIX = 6'd40;

	localparam logic [7:0] LEGACY_KEY   = 8'h1c;
	localparam logic [7:0] LEGACY_INTER = 8'h2c;
	localparam logic [7:0] LEGACY_AVC   = 8'h01;
	localparam logic [7:0] ENH_KEY      = 8'h91;
	localparam logic [7:0] ENH_INTER    = 8'ha1;
	localparam logic [7:0] FOURCC_0     = 8'h68;
	localparam logic [7:0] FOURCC_1     = 8'h76;
	localparam logic [7:0] FOURCC_2     = 8'h63;
	localparam logic [7:0] FOURCC_3     = 8'h31;

	localparam int          STEP_W         = 4;
	localparam logic [STEP_W-1:0] LEGACY_HDR_LEN = 4'd5;
	localparam logic [STEP_W-1:0] ENH_HDR_LEN    = 4'd8;
	localparam logic [STEP_W-1:0] PREFIX_LEN     = 4'd4;

	// Length added by the first NAL of a message (header plus prefix) and by later NALs.
	localparam logic [3:0] FIRST_ADD_LEGACY = 4'd9;
	localparam logic [3:0] FIRST_ADD_ENH    = 4'd12;
	localparam logic [3:0] NEXT_ADD         = 4'd4;

	// One unit of work handed from the front end to the back end.
	typedef struct packed {
		cmd_t        op;
		logic [7:0]  data;
		logic        close;
		logic [31:0] close_time;
		logic [31:0] close_length;
		logic        close_pic;
		logic        header;
		logic        enhanced;
		logic        key;
		logic [23:0] cts;
		logic [31:0] len;
	} desc_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [31:0] message_time;
		logic [31:0] message_length;
		logic        picture_start_seen;
		logic        last_of_run;
	} result_t;

	function automatic logic [7:0] hdr_byte(input logic enh, input logic key,
			input logic [2:0] idx, input logic [23:0] cts);
		logic [7:0] b;
		b = 8'h00;
		if (enh) begin
			unique case (idx)
				3'd0: b = key ? ENH_KEY : ENH_INTER;
				3'd1: b = FOURCC_0;
				3'd2: b = FOURCC_1;
				3'd3: b = FOURCC_2;
				3'd4: b = FOURCC_3;
				3'd5: b = cts[23:16];
				3'd6: b = cts[15:8];
				default: b = cts[7:0];
			endcase
		end else begin
			unique case (idx)
				3'd0: b = key ? LEGACY_KEY : LEGACY_INTER;
				3'd1: b = LEGACY_AVC;
				3'd2: b = cts[23:16];
				3'd3: b = cts[15:8];
				default: b = cts[7:0];
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// File: rtl/hevcf_front.sv
// Front end of the framer: accepts items, keeps the message state and classifies each item.
// Depends on hevcf_pkg; feeds hevcf_queue.
`default_nettype none

module hevcf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_write,
	input  wire logic           cfg_data,
	input  wire logic           in_push,
	input  wire hevcf_pkg::cmd_t command,
	input  wire logic [5:0]     nal_type,
	input  wire logic [31:0]    presentation_time,
	input  wire logic [31:0]    decode_time,
	input  wire logic [31:0]    nal_length,
	input  wire logic           is_key,
	input  wire logic           starts_picture,
	input  wire logic           has_start_code,
	input  wire logic [7:0]     data_byte,
	input  wire logic           q_full,
	output logic                q_push,
	output hevcf_pkg::desc_t    q_desc
);
	import hevcf_pkg::*;

	logic        enhanced_mode_q;
	logic        message_open_q;
	logic        append_pending_q;
	logic [31:0] last_timestamp_q;
	logic [31:0] accumulated_length_q;
	logic        start_flag_q;

	logic        accept;
	logic        is_begin;
	logic        close;
	logic        stay_open;
	logic [31:0] acc_base;
	logic [3:0]  add_const;
	logic [33:0] sum;
	logic [31:0] sum_sat;
	logic        param_set;
	logic [23:0] cts_low;

	assign accept   = in_push && !q_full;
	assign is_begin = (command == CMD_BEGIN);

	// A begin closes on a new time or start code, except after a parameter set or SEI.
	assign close = message_open_q && !append_pending_q &&
		((last_timestamp_q != presentation_time) || has_start_code);
	assign stay_open = message_open_q && !close;

	assign acc_base  = close ? 32'd0 : accumulated_length_q;
	assign add_const = stay_open ? NEXT_ADD : (enhanced_mode_q ? FIRST_ADD_ENH : FIRST_ADD_LEGACY);
	assign sum       = {2'b00, acc_base} + {30'd0, add_const} + {2'b00, nal_length};
	assign sum_sat   = (sum[33:32] != 2'b00) ? 32'hffff_ffff : sum[31:0];
	// Only the low 24 bits of the composition offset are sent.
	assign cts_low   = presentation_time[23:0] - decode_time[23:0];

	assign param_set = (nal_type == NAL_VPS) || (nal_type == NAL_SPS) || (nal_type == NAL_PPS) ||
		(nal_type == NAL_SEI_PREFIX) || (nal_type == NAL_SEI_SUFFIX);

	// Bytes that arrive with no open message are dropped and never reach the queue.
	assign q_push = accept && (is_begin || message_open_q);

	always_comb begin
		q_desc              = '0;
		q_desc.op           = command;
		q_desc.data         = data_byte;
		q_desc.close        = is_begin && close;
		q_desc.close_time   = last_timestamp_q;
		q_desc.close_length = accumulated_length_q;
		q_desc.close_pic    = start_flag_q;
		q_desc.header       = !stay_open;
		q_desc.enhanced     = enhanced_mode_q;
		q_desc.key          = is_key;
		q_desc.cts          = cts_low;
		q_desc.len          = nal_length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enhanced_mode_q <= 1'b0;
		end else if (cfg_write) begin
			enhanced_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			message_open_q       <= 1'b0;
			append_pending_q     <= 1'b0;
			last_timestamp_q     <= '0;
			accumulated_length_q <= '0;
			start_flag_q         <= 1'b0;
		end else if (accept && is_begin) begin
			message_open_q       <= 1'b1;
			append_pending_q     <= param_set;
			last_timestamp_q     <= presentation_time;
			accumulated_length_q <= sum_sat;
			start_flag_q         <= (start_flag_q && !close) || starts_picture;
		end
	end

`ifndef SYNTHESIS
	a_begin_opens: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_begin |=> message_open_q)
		else $error("begin item did not open a message");

	a_length_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_begin && !close |=> accumulated_length_q >= $past(accumulated_length_q))
		else $error("message length shrank without a close");

	a_drop_orphan_byte: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_begin && !message_open_q |-> !q_push)
		else $error("byte without an open message was queued");
`endif

endmodule

`default_nettype wire

// File: rtl/hevcf_queue.sv
// Short work queue between the framer front end and back end.
// Depends on hevcf_pkg for the entry type.
`default_nettype none

module hevcf_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hevcf_pkg::desc_t wr_desc,
	output logic                  full,
	input  wire logic             pop,
	output hevcf_pkg::desc_t      head,
	output logic                  empty
);
	import hevcf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t          mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/hevcf_back.sv
// Back end: expands queued entries to results, one per cycle unless output stalls.
// Depends on hevcf_pkg; reads the head of hevcf_queue and drives the output register.
`default_nettype none

module hevcf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_empty,
	input  wire hevcf_pkg::desc_t q_head,
	output logic                  q_pop,
	input  wire logic             out_pop,
	output logic                  out_valid,
	output hevcf_pkg::result_t    out_res
);
	import hevcf_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              emit;
	logic              last;
	logic [STEP_W-1:0] close_cnt;
	logic [STEP_W-1:0] hdr_cnt;
	logic [STEP_W-1:0] total;
	logic [STEP_W-1:0] j;
	logic [1:0]        k;
	result_t           res_d;

	// A new result may be formed when the output register is free or is emptied this cycle.
	assign emit = !q_empty && (!res_valid_q || out_pop);

	assign close_cnt = q_head.close ? STEP_W'(1) : '0;
	assign hdr_cnt   = !q_head.header ? '0 : (q_head.enhanced ? ENH_HDR_LEN : LEGACY_HDR_LEN);
	assign total     = close_cnt + hdr_cnt + PREFIX_LEN;
	assign j         = step_q - close_cnt;
	assign k         = 2'(j - hdr_cnt);
	assign last      = (q_head.op == CMD_BYTE) || (step_q == total - 1'b1);

	always_comb begin
		res_d             = '0;
		res_d.kind        = KIND_BYTE;
		res_d.last_of_run = last;
		if (q_head.op == CMD_BYTE) begin
			res_d.out_byte = q_head.data;
		end else if (q_head.close && (step_q == '0)) begin
			res_d.kind               = KIND_CLOSE;
			res_d.message_time       = q_head.close_time;
			res_d.message_length     = q_head.close_length;
			res_d.picture_start_seen = q_head.close_pic;
		end else if (j < hdr_cnt) begin
			res_d.out_byte = hdr_byte(q_head.enhanced, q_head.key, j[2:0], q_head.cts);
		end else begin
			unique case (k)
				2'd0: res_d.out_byte = q_head.len[31:24];
				2'd1: res_d.out_byte = q_head.len[23:16];
				2'd2: res_d.out_byte = q_head.len[15:8];
				default: res_d.out_byte = q_head.len[7:0];
			endcase
		end
	end

	assign q_pop     = emit && last;
	assign out_valid = res_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				step_q <= last ? '0 : step_q + 1'b1;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (out_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (step_q < total))
		else $error("sequencer step ran past the end of its entry");

	a_step_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> step_q == '0)
		else $error("sequencer step not cleared after finishing an entry");

	a_close_first: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res_d.kind == KIND_CLOSE |-> step_q == '0 && !res_d.last_of_run)
		else $error("close result out of place in its run");
`endif

endmodule

`default_nettype wire

// File: rtl/hevc_nal_to_flv_video_tag_framer_core.sv
// Top level of the HEVC NAL to FLV video tag framer.
// Depends on hevcf_pkg, hevcf_front, hevcf_queue and hevcf_back.
`default_nettype none

// The framer turns a stream of HEVC NAL units into FLV/RTMP video tag bodies. Each NAL is given
// as one begin item (command 0, with its type, timestamps, length and flags) followed by its
// payload bytes (command 1, one byte per item). A begin item may first close the open message,
// which yields one close result with the message timestamp, saturating byte length and
// picture-start flag; the first NAL of a message then gets a 5-byte legacy header or, with
// enhanced_mode set through cfg_write/cfg_data, an 8-byte hvc1 header, and every NAL gets a
// 4-byte big-endian length prefix. Payload bytes pass through unchanged; bytes that arrive with
// no open message are dropped. The front end takes one item per cycle as long as its work queue
// (QUEUE_DEPTH entries) has room. The back end delivers one result item per cycle from the queue
// head into an output register while it is free or being popped; a payload byte yields one
// result and a begin item yields 4 to 13 results (close result, header, prefix), and a run of
// payload bytes after a begin item streams at full rate once the header has drained. The first
// result of an item passes through its queue entry and then the output register. The user must
// write the configuration only while no item is in flight; the block itself does not enforce it.
module hevc_nal_to_flv_video_tag_framer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_write,
	input  wire logic            cfg_data,
	input  wire logic            push,
	output logic                 full,
	input  wire hevcf_pkg::cmd_t command,
	input  wire logic [5:0]      nal_type,
	input  wire logic [31:0]     presentation_time,
	input  wire logic [31:0]     decode_time,
	input  wire logic [31:0]     nal_length,
	input  wire logic            is_key,
	input  wire logic            starts_picture,
	input  wire logic            has_start_code,
	input  wire logic [7:0]      data_byte,
	output logic                 empty,
	input  wire logic            pop,
	output logic                 kind,
	output logic [7:0]           out_byte,
	output logic [31:0]          message_time,
	output logic [31:0]          message_length,
	output logic                 picture_start_seen,
	output logic                 last_of_run
);
	import hevcf_pkg::*;

	logic    q_push;
	desc_t   q_wr;
	logic    q_full;
	logic    q_pop;
	desc_t   q_head;
	logic    q_empty;
	logic    out_valid;
	result_t out_res;

	// The front end classifies each item and updates the message state at acceptance time.
	hevcf_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_data          (cfg_data),
		.in_push           (push),
		.command           (command),
		.nal_type          (nal_type),
		.presentation_time (presentation_time),
		.decode_time       (decode_time),
		.nal_length        (nal_length),
		.is_key            (is_key),
		.starts_picture    (starts_picture),
		.has_start_code    (has_start_code),
		.data_byte         (data_byte),
		.q_full            (q_full),
		.q_push            (q_push),
		.q_desc            (q_wr)
	);

	// The queue lets a burst of begin items pile up while the back end drains headers.
	hevcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_desc (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	// The back end walks each entry one result per cycle into the output register while it is free or being popped.
	hevcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_pop   (pop),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign full               = q_full;
	assign empty              = !out_valid;
	assign kind               = out_res.kind;
	assign out_byte           = out_res.out_byte;
	assign message_time       = out_res.message_time;
	assign message_length     = out_res.message_length;
	assign picture_start_seen = out_res.picture_start_seen;
	assign last_of_run        = out_res.last_of_run;

endmodule

`default_nettype wire
